FILE: sv/smat_pkg.sv
// Shared constants for the sliding-mean thermocouple temperature block.
package smat_pkg;

    localparam int unsigned SAMPLE_W       = 12;
    localparam int unsigned SAMPLE_MAX     = 4095;
    localparam int unsigned TEMP_W         = 8;
    localparam int unsigned TEMP_OFFSET    = 540;
    localparam int unsigned TEMP_DIVISOR   = 27;
    localparam int unsigned WINDOW_DEFAULT = 8;

    // Width of (sample + offset), the numerator of the raw conversion.
    localparam int unsigned RAW_NUM_W = $clog2(SAMPLE_MAX + TEMP_OFFSET + 1);

endpackage

FILE: sv/smat_ram.sv
// Generic single-port-write, registered-read RAM (read returns the old data on a collision).
module smat_ram #(
    parameter int unsigned WIDTH = smat_pkg::SAMPLE_W,
    parameter int unsigned DEPTH = smat_pkg::WINDOW_DEFAULT,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/smat_cdiv.sv
// Division of an unsigned value by a constant through an exact reciprocal multiply.
module smat_cdiv #(
    parameter int unsigned IN_W    = smat_pkg::RAW_NUM_W,
    parameter int unsigned DIVISOR = smat_pkg::TEMP_DIVISOR,
    parameter int unsigned OUT_W   = smat_pkg::TEMP_W
) (
    input  logic [IN_W-1:0]  i_num,
    output logic [OUT_W-1:0] o_quot
);

    // With 2**SHIFT >= 2**IN_W * DIVISOR the rounded-up reciprocal gives the exact
    // floor for every numerator that fits in IN_W bits.
    localparam int unsigned SHIFT = IN_W + $clog2(DIVISOR);
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int unsigned RECIP_W = $clog2(RECIP + 1);
    localparam int unsigned PROD_W = (IN_W + RECIP_W > SHIFT + OUT_W) ?
                                     (IN_W + RECIP_W) : (SHIFT + OUT_W);

    logic [PROD_W-1:0] prod;

    assign prod   = PROD_W'(i_num) * PROD_W'(RECIP);
    assign o_quot = prod[SHIFT +: OUT_W];

endmodule

FILE: sv/sliding_mean_adc_to_temperature.sv
// Top level: sliding-window mean of ADC samples converted to degrees.
//
//  beat     | valid    | stall    | payload
//  ---------+----------+----------+------------------------------------------
//  sample   | i_valid  | o_stall  | i_adc_sample
//  result   | o_valid  | i_stall  | o_filtered_temp_c, o_raw_temp_c
//
// One sample per cycle while o_stall is low; the result passes r_s1_* then r_out_*.
// The ring update and running sum close in the accept cycle, the two constant
// divisions (reciprocal multiplies) sit between the stage register and the output.
// Reset is synchronous; the ring reads as zero through per-entry valid bits, so no
// clearing pass is needed and samples are accepted right after reset.
// A stalled result holds, and the pipeline keeps taking samples until both stages fill.
module sliding_mean_adc_to_temperature #(
    parameter int unsigned WINDOW = smat_pkg::WINDOW_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [smat_pkg::SAMPLE_W-1:0] i_adc_sample,
    output logic                          o_stall,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [smat_pkg::TEMP_W-1:0]   o_filtered_temp_c,
    output logic [smat_pkg::TEMP_W-1:0]   o_raw_temp_c
);

    localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned SUM_W  = $clog2(WINDOW * smat_pkg::SAMPLE_MAX + 1);
    localparam int unsigned X_W    =
        $clog2(WINDOW * (smat_pkg::SAMPLE_MAX + smat_pkg::TEMP_OFFSET) + 1);
    localparam int unsigned RAW_W  = smat_pkg::RAW_NUM_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    // Ring and running-sum state.
    logic [SLOT_W-1:0]             r_slot;
    logic [SLOT_W-1:0]             n_slot;
    logic [SUM_W-1:0]              r_sum;
    logic [SUM_W-1:0]              n_sum;
    logic [WINDOW-1:0]             r_filled;
    logic                          r_rd_valid;
    logic                          r_byp;
    logic [smat_pkg::SAMPLE_W-1:0] r_byp_data;
    logic [smat_pkg::SAMPLE_W-1:0] rd_data;
    logic [smat_pkg::SAMPLE_W-1:0] oldest;

    // Pipeline stages.
    logic                          r_s1_valid;
    logic [SUM_W-1:0]              r_s1_sum;
    logic [smat_pkg::SAMPLE_W-1:0] r_s1_sample;
    logic                          r_out_valid;
    logic [smat_pkg::TEMP_W-1:0]   r_out_filt;
    logic [smat_pkg::TEMP_W-1:0]   r_out_raw;

    logic                          out_ready;
    logic                          s1_ready;
    logic                          accept;
    logic [X_W-1:0]                filt_num;
    logic [RAW_W-1:0]              raw_num;
    logic [smat_pkg::TEMP_W-1:0]   filt_q;
    logic [smat_pkg::TEMP_W-1:0]   raw_q;

    assign out_ready = !r_out_valid || !i_stall;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign accept    = i_valid && s1_ready;
    assign o_stall   = !s1_ready;

    always_comb begin
        n_slot = r_slot;
        if (accept) begin
            n_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
        end
    end

    // The RAM always prefetches the entry for the next write slot. With a window of
    // one the slot never moves, so the sample just written is forwarded instead.
    assign oldest = r_byp ? r_byp_data : (r_rd_valid ? rd_data : '0);
    assign n_sum  = r_sum - SUM_W'(oldest) + SUM_W'(i_adc_sample);

    smat_ram #(
        .WIDTH (smat_pkg::SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_slot),
        .i_wr_data (i_adc_sample),
        .i_rd_addr (n_slot),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_sum       <= '0;
            r_filled    <= '0;
            r_rd_valid  <= 1'b0;
            r_byp       <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_filled[n_slot];
            r_byp      <= accept && (n_slot == r_slot);
            r_slot     <= n_slot;
            if (accept) begin
                r_sum            <= n_sum;
                r_filled[r_slot] <= 1'b1;
            end
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // The mean and the offset fold into one division:
    // floor((floor(sum / W) + 540) / 27) == floor((sum + 540 * W) / (27 * W)).
    assign filt_num = X_W'(r_s1_sum) + X_W'(smat_pkg::TEMP_OFFSET * WINDOW);
    assign raw_num  = RAW_W'(r_s1_sample) + RAW_W'(smat_pkg::TEMP_OFFSET);

    smat_cdiv #(
        .IN_W    (X_W),
        .DIVISOR (smat_pkg::TEMP_DIVISOR * WINDOW),
        .OUT_W   (smat_pkg::TEMP_W)
    ) u_filt_div (
        .i_num  (filt_num),
        .o_quot (filt_q)
    );

    smat_cdiv #(
        .IN_W    (RAW_W),
        .DIVISOR (smat_pkg::TEMP_DIVISOR),
        .OUT_W   (smat_pkg::TEMP_W)
    ) u_raw_div (
        .i_num  (raw_num),
        .o_quot (raw_q)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byp_data  <= i_adc_sample;
            r_s1_sum    <= n_sum;
            r_s1_sample <= i_adc_sample;
        end
        if (out_ready && r_s1_valid) begin
            r_out_filt <= filt_q;
            r_out_raw  <= raw_q;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_filtered_temp_c = r_out_filt;
    assign o_raw_temp_c      = r_out_raw;

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= LAST_SLOT)
        else $error("write slot out of window range");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_ready |=> r_s1_valid && $stable(r_s1_sum) && $stable(r_s1_sample))
        else $error("stage one lost or changed a waiting beat");

    a_bypass_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp |-> (WINDOW == 1))
        else $error("forwarding used with a window wider than one");

endmodule
